[rtl/core/caseless_substring_search_macros.svh]
// assertion macros for the caseless substring search block
`ifndef CASELESS_SUBSTRING_SEARCH_MACROS_SVH
`define CASELESS_SUBSTRING_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define CCS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("caseless search: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define CCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("caseless search: next-cycle check failed");

`else

`define CCS_ASSERT_SAME(label, ante, cons)
`define CCS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/ccs_pkg.sv]
// shared types, constants and helpers of the caseless substring search
package ccs_pkg;

	localparam int MAX_NEEDLE_DEF = 16;
	localparam int POS_WIDTH_DEF  = 16;

	localparam int NEEDLE_BYTES = 16;
	localparam int NEEDLE_W     = 8 * NEEDLE_BYTES;
	localparam int LEN_W        = 5;
	localparam int DATA_W       = 64;
	localparam int ADDR_W       = 5;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_NEEDLE_LO  = 2'd0,
		REG_NEEDLE_HI  = 2'd1,
		REG_NEEDLE_LEN = 2'd2
	} reg_idx_t;

	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef struct packed {
		logic [NEEDLE_W-1:0] needle;
		logic [LEN_W-1:0]    len;
	} cfg_t;

	// ascii upper case to lower case, everything else unchanged
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c | 8'h20;
		end
		return r;
	endfunction

endpackage

[rtl/core/ccs_regs.sv]
// apb register file holding the needle and its length
module ccs_regs
	import ccs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	logic [DATA_W-1:0] needle_lo_q;
	logic [DATA_W-1:0] needle_hi_q;
	logic [LEN_W-1:0]  needle_len_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign idx   = reg_idx_t'(paddr[4:3]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo_q  <= '0;
			needle_hi_q  <= '0;
			needle_len_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_NEEDLE_LO:  needle_lo_q  <= pwdata;
				REG_NEEDLE_HI:  needle_hi_q  <= pwdata;
				REG_NEEDLE_LEN: needle_len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NEEDLE_LO:  prdata = needle_lo_q;
			REG_NEEDLE_HI:  prdata = needle_hi_q;
			REG_NEEDLE_LEN: prdata = DATA_W'(needle_len_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.needle = {needle_hi_q, needle_lo_q};
	assign cfg.len    = needle_len_q;

endmodule

[rtl/core/ccs_cell.sv]
// one window cell: holds a haystack byte and compares the incoming byte
module ccs_cell
	import ccs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       flush,
	input  logic [7:0] byte_in,
	input  logic       valid_in,
	input  logic [7:0] target,
	input  logic       active,
	output logic [7:0] byte_out,
	output logic       valid_out,
	output logic       hit
);

	logic [7:0] byte_q;
	logic       valid_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flush) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= valid_in;
		end
	end

	// judged on the byte this cell holds after the shift
	assign hit       = !active || (valid_in && (fold_case(byte_in) == fold_case(target)));
	assign byte_out  = byte_q;
	assign valid_out = valid_q;

endmodule

[rtl/core/caseless_substring_search.sv]
// top level of the caseless substring search: window cells, control, output register
// latency: a result appears on res_valid the cycle after the haystack byte is taken
// throughput: one haystack byte per cycle while hay_ready is high, set by the single window shift per byte
// hay_ready drops only while a result waits in the output register and res_ready is low
// reset clears the window valid bits, position, done flag, result valid bit and the
// needle registers; the window bytes and the result payload are not reset
`include "caseless_substring_search_macros.svh"

module caseless_substring_search
	import ccs_pkg::*;
#(
	parameter int MAX_NEEDLE = MAX_NEEDLE_DEF,
	parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// haystack channel
	input  logic                 hay_valid,
	output logic                 hay_ready,
	input  logic [7:0]           hay_byte,
	// result channel
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 status,
	output logic [POS_WIDTH-1:0] match_start,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	cfg_t                 cfg;
	logic [7:0]           needle_b [NEEDLE_BYTES];
	logic [LEN_W-1:0]     len_eff;

	// window chain, cell 0 holds the newest byte
	logic [7:0]           win_byte [MAX_NEEDLE];
	logic [MAX_NEEDLE-1:0] win_valid;
	logic [MAX_NEEDLE-1:0] cell_hit;

	logic                 accept;
	logic                 term;
	logic                 empty_path;
	logic                 shift;
	logic                 flush;
	logic                 match;
	logic                 emit;
	logic                 emit_status;
	logic [POS_WIDTH-1:0] emit_start;

	logic [POS_WIDTH-1:0] position_q;
	logic                 done_q;
	logic                 res_valid_q;
	logic                 status_q;
	logic [POS_WIDTH-1:0] match_start_q;

	assign pready = 1'b1;

	ccs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	always_comb begin
		for (int j = 0; j < NEEDLE_BYTES; j++) begin
			needle_b[j] = cfg.needle[8*j +: 8];
		end
	end

	// lengths beyond the window act as a full window
	assign len_eff = (cfg.len > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : cfg.len;

	// handshake: a waiting result only blocks input when it is not being taken
	assign hay_ready  = !res_valid_q || res_ready;
	assign accept     = hay_valid && hay_ready;
	assign term       = (hay_byte == 8'h00);
	// empty needle reports found at index 0 once per haystack, no shift
	assign empty_path = !done_q && (len_eff == '0);
	assign shift      = accept && !empty_path && !term;
	assign flush      = accept && term;

	// cell k lines up with needle byte len-1-k, so the needle tail meets the newest byte
	for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
		logic [LEN_W-1:0] nidx;
		logic [7:0]       byte_in;
		logic             valid_in;

		assign nidx = len_eff - LEN_W'(k) - LEN_W'(1);

		if (k == 0) begin : g_head
			assign byte_in  = hay_byte;
			assign valid_in = 1'b1;
		end else begin : g_body
			assign byte_in  = win_byte[k-1];
			assign valid_in = win_valid[k-1];
		end

		ccs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.flush     (flush),
			.byte_in   (byte_in),
			.valid_in  (valid_in),
			.target    (needle_b[nidx[3:0]]),
			.active    (LEN_W'(k) < len_eff),
			.byte_out  (win_byte[k]),
			.valid_out (win_valid[k]),
			.hit       (cell_hit[k])
		);
	end

	// cell valid bits stand in for the fill count: an inactive cell always hits
	assign match = &cell_hit;

	always_comb begin
		emit        = 1'b0;
		emit_status = STATUS_FOUND;
		emit_start  = '0;
		if (accept) begin
			if (empty_path) begin
				emit = 1'b1;
			end else if (term) begin
				emit        = !done_q;
				emit_status = STATUS_NOT_FOUND;
			end else begin
				emit       = !done_q && match;
				emit_start = position_q - (POS_WIDTH'(len_eff) - POS_WIDTH'(1));
			end
		end
	end

	// haystack position and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			done_q     <= 1'b0;
		end else if (flush) begin
			position_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (shift && (position_q != '1)) begin
				position_q <= position_q + POS_WIDTH'(1);
			end
			if (emit) begin
				done_q <= 1'b1;
			end
		end
	end

	// output register: valid under reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q      <= emit_status;
			match_start_q <= emit_start;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign match_start = match_start_q;

	// once a match is reported, ordinary bytes give nothing until the terminator
	`CCS_ASSERT_SAME(a_done_silent, accept && done_q && !term, !emit)
	// a reported match always marks the haystack as done
	`CCS_ASSERT_NEXT(a_emit_sets_done, emit && !flush, done_q)
	// not-found transactions carry a zero start index
	`CCS_ASSERT_SAME(a_notfound_zero,
		res_valid_q && (status_q == STATUS_NOT_FOUND), match_start_q == '0)
	// position only moves back on the terminator
	`CCS_ASSERT_NEXT(a_pos_monotonic, !flush, position_q >= $past(position_q))

endmodule
